// ===== rtl/core/scr_pkg.sv =====
// Shared types, constants and helpers for the source character reader.
// Used by the interfaces, the step core, the output queue and the top level.
package scr_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_COMMENT_DEPTH_DEF = 255;
    localparam int COUNTER_BITS_DEF      = 16;

    // Field widths
    localparam int CHAR_W   = 21;
    localparam int POS_W    = 16;
    localparam int TAB_W    = 5;
    localparam int NAME_W   = 16;
    localparam int HEXACC_W = 16;

    // Register reset, fixed column costs and limits
    localparam logic [TAB_W-1:0]  TAB_ADVANCE_RST = 5'd4;
    localparam int                HEX_ESC_COLS    = 6;
    localparam int                NAMED_ESC_COLS  = 3;
    localparam logic [NAME_W-1:0] NAME_LEN_MAX    = 16'hFFFF;
    localparam logic [1:0]        HEX_LAST_DIGIT  = 2'd3;

    // Output queue
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = 2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL    = 21'h00;
    localparam logic [CHAR_W-1:0] CH_TAB    = 21'h09;
    localparam logic [CHAR_W-1:0] CH_LF     = 21'h0A;
    localparam logic [CHAR_W-1:0] CH_CR     = 21'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 21'h20;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 21'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 21'h29;
    localparam logic [CHAR_W-1:0] CH_STAR   = 21'h2A;
    localparam logic [CHAR_W-1:0] CH_COLON  = 21'h3A;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 21'h5B;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 21'h5C;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 21'h5D;

    // Result status codes
    typedef enum logic [2:0] {
        ST_CHAR     = 3'd0,
        ST_END      = 3'd1,
        ST_UNTERM   = 3'd2,
        ST_NAMED    = 3'd3,
        ST_DEPTH    = 3'd4
    } t_status;

    // Scanner phase, one-hot
    typedef enum logic [7:0] {
        PH_NORMAL  = 8'b0000_0001,
        PH_CRSKIP  = 8'b0000_0010,
        PH_PAREN   = 8'b0000_0100,
        PH_BSLASH  = 8'b0000_1000,
        PH_HEX     = 8'b0001_0000,
        PH_NAMED   = 8'b0010_0000,
        PH_COMMENT = 8'b0100_0000,
        PH_CCRSKIP = 8'b1000_0000
    } t_phase;

    // One result word
    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic [POS_W-1:0]  line_number;
        logic [POS_W-1:0]  column_number;
        t_status           status;
    } t_result;

    // Up to two result words produced by one input word
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

    // Hex digit decode: {valid, value}
    function automatic logic [4:0] hex_value(input logic [CHAR_W-1:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= 21'h30 && c <= 21'h39) begin
            r = {1'b1, 4'(c - 21'h30)};
        end else if (c >= 21'h61 && c <= 21'h66) begin
            r = {1'b1, 4'(c - 21'h57)};
        end else if (c >= 21'h41 && c <= 21'h46) begin
            r = {1'b1, 4'(c - 21'h37)};
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/scr_if.sv =====
// Valid/ready channel interfaces for the source character reader.
// Depends on scr_pkg for field widths and the status type.
interface scr_in_if;
    logic                      valid;
    logic                      ready;
    logic [scr_pkg::CHAR_W-1:0] char_code;
    logic                      end_of_input;

    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface scr_out_if;
    logic                       valid;
    logic                       ready;
    logic [scr_pkg::CHAR_W-1:0] out_char;
    logic [scr_pkg::POS_W-1:0]  line_number;
    logic [scr_pkg::POS_W-1:0]  column_number;
    scr_pkg::t_status           status;

    modport source (output valid, output out_char, output line_number,
                    output column_number, output status, input ready);
    modport sink   (input valid, input out_char, input line_number,
                    input column_number, input status, output ready);
endinterface

// ===== rtl/core/scr_core.sv =====
// Scanner state and per-word step logic: phase, comment depth, escapes, counters.
// Depends on scr_pkg; produces up to two result words per accepted input word.
module scr_core #(
    parameter int MAX_COMMENT_DEPTH = scr_pkg::MAX_COMMENT_DEPTH_DEF,
    parameter int COUNTER_BITS      = scr_pkg::COUNTER_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [scr_pkg::TAB_W-1:0]   i_cfg_wdata,
    input  logic                        i_accept,
    input  logic [scr_pkg::CHAR_W-1:0]  i_char_code,
    input  logic                        i_end_of_input,
    output scr_pkg::t_push              o_push
);
    localparam int CB = COUNTER_BITS;
    localparam int DW = $clog2(MAX_COMMENT_DEPTH + 1);
    localparam int SW = ((CB > scr_pkg::NAME_W + 1) ? CB : scr_pkg::NAME_W + 1) + 1;
    localparam logic [SW-1:0] CntMax   = SW'({CB{1'b1}});
    localparam logic [DW-1:0] DepthMax = DW'(MAX_COMMENT_DEPTH);
    localparam logic [DW-1:0] DepthOne = DW'(1);
    localparam logic [CB-1:0] CntOne   = CB'(1);

    // State
    scr_pkg::t_phase                r_phase, n_phase;
    logic [DW-1:0]                  r_depth, n_depth;
    logic [1:0]                     r_mark, n_mark;     // 0 none, 1 star, 2 paren
    logic [1:0]                     r_hex_cnt, n_hex_cnt;
    logic [scr_pkg::HEXACC_W-1:0]   r_hex_acc, n_hex_acc;
    logic                           r_hex_stop, n_hex_stop;
    logic [scr_pkg::NAME_W-1:0]     r_name_len, n_name_len;
    logic [CB-1:0]                  r_line, n_line;
    logic [CB-1:0]                  r_col, n_col;
    logic [scr_pkg::TAB_W-1:0]      r_tab_advance;

    localparam logic [1:0] MARK_NONE  = 2'd0;
    localparam logic [1:0] MARK_STAR  = 2'd1;
    localparam logic [1:0] MARK_PAREN = 2'd2;

    logic [SW-1:0]  d1, d2, name_sum, name_step, sum1, sum2, line_sum;
    logic [CB-1:0]  col1, col2, line1;
    logic [4:0]     hv;
    logic           is_tab;
    scr_pkg::t_push push;

    function automatic scr_pkg::t_result mk(input logic [scr_pkg::CHAR_W-1:0] ch,
                                            input logic [CB-1:0] ln,
                                            input logic [CB-1:0] cl,
                                            input scr_pkg::t_status st);
        scr_pkg::t_result r;
        logic [CB+scr_pkg::POS_W-1:0] lx, cx;
        lx = {{scr_pkg::POS_W{1'b0}}, ln};
        cx = {{scr_pkg::POS_W{1'b0}}, cl};
        r.out_char      = ch;
        r.line_number   = lx[scr_pkg::POS_W-1:0];
        r.column_number = cx[scr_pkg::POS_W-1:0];
        r.status        = st;
        return r;
    endfunction

    // Column deltas: d1 for the first step of this word, d2 for a char after a prefix
    assign is_tab    = (i_char_code == scr_pkg::CH_TAB);
    assign name_sum  = SW'(r_name_len) + SW'(scr_pkg::NAMED_ESC_COLS);
    assign name_step = (name_sum > CntMax) ? CntMax : name_sum;
    assign d2        = is_tab ? SW'(r_tab_advance) : SW'(1);

    always_comb begin
        d1 = SW'(1);
        if (r_phase == scr_pkg::PH_NORMAL || r_phase == scr_pkg::PH_COMMENT) begin
            d1 = d2;
        end else if (r_phase == scr_pkg::PH_HEX) begin
            d1 = SW'(scr_pkg::HEX_ESC_COLS);
        end else if (r_phase == scr_pkg::PH_NAMED) begin
            d1 = name_step;
        end
    end

    // Saturating counter adders
    assign sum1     = SW'(r_col) + d1;
    assign col1     = (sum1 > CntMax) ? {CB{1'b1}} : sum1[CB-1:0];
    assign sum2     = SW'(col1) + d2;
    assign col2     = (sum2 > CntMax) ? {CB{1'b1}} : sum2[CB-1:0];
    assign line_sum = SW'(r_line) + SW'(1);
    assign line1    = (line_sum > CntMax) ? {CB{1'b1}} : line_sum[CB-1:0];

    assign hv = scr_pkg::hex_value(i_char_code);

    // Step logic
    always_comb begin
        logic [scr_pkg::HEXACC_W-1:0] acc;
        n_phase    = r_phase;
        n_depth    = r_depth;
        n_mark     = r_mark;
        n_hex_cnt  = r_hex_cnt;
        n_hex_acc  = r_hex_acc;
        n_hex_stop = r_hex_stop;
        n_name_len = r_name_len;
        n_line     = r_line;
        n_col      = r_col;
        push.v0    = 1'b0;
        push.v1    = 1'b0;
        push.r0    = mk(scr_pkg::CH_NUL, r_line, r_col, scr_pkg::ST_CHAR);
        push.r1    = push.r0;
        acc        = r_hex_acc;

        if (i_end_of_input) begin
            // Flush what is pending, then the end word
            case (r_phase)
                scr_pkg::PH_PAREN: begin
                    push.v0 = 1'b1;
                    push.r0 = mk(scr_pkg::CH_LPAREN, r_line, col1, scr_pkg::ST_CHAR);
                    n_col   = col1;
                end
                scr_pkg::PH_BSLASH: begin
                    push.v0 = 1'b1;
                    push.r0 = mk(scr_pkg::CH_BSLASH, r_line, col1, scr_pkg::ST_CHAR);
                    n_col   = col1;
                end
                scr_pkg::PH_HEX: begin
                    push.v0 = 1'b1;
                    push.r0 = mk(scr_pkg::CHAR_W'(r_hex_acc), r_line, col1,
                                 scr_pkg::ST_CHAR);
                    n_col   = col1;
                end
                scr_pkg::PH_NAMED: begin
                    push.v0 = 1'b1;
                    push.r0 = mk(scr_pkg::CH_NUL, r_line, col1, scr_pkg::ST_NAMED);
                    n_col   = col1;
                end
                scr_pkg::PH_COMMENT, scr_pkg::PH_CCRSKIP: begin
                    push.v0 = 1'b1;
                    push.r0 = mk(scr_pkg::CH_NUL, r_line, r_col, scr_pkg::ST_UNTERM);
                end
                default: begin
                end
            endcase
            if (push.v0) begin
                push.v1 = 1'b1;
                push.r1 = mk(scr_pkg::CH_NUL, r_line, n_col, scr_pkg::ST_END);
            end else begin
                push.v0 = 1'b1;
                push.r0 = mk(scr_pkg::CH_NUL, r_line, r_col, scr_pkg::ST_END);
            end
            n_phase    = scr_pkg::PH_NORMAL;
            n_depth    = '0;
            n_mark     = MARK_NONE;
            n_hex_cnt  = '0;
            n_hex_acc  = '0;
            n_hex_stop = 1'b0;
            n_name_len = '0;
        end else begin
            case (r_phase)
                scr_pkg::PH_NORMAL: begin
                    case (i_char_code)
                        scr_pkg::CH_CR, scr_pkg::CH_LF: begin
                            push.v0 = 1'b1;
                            push.r0 = mk(scr_pkg::CH_LF, line1, CntOne, scr_pkg::ST_CHAR);
                            n_line  = line1;
                            n_col   = CntOne;
                            if (i_char_code == scr_pkg::CH_CR) begin
                                n_phase = scr_pkg::PH_CRSKIP;
                            end
                        end
                        scr_pkg::CH_TAB: begin
                            push.v0 = 1'b1;
                            push.r0 = mk(scr_pkg::CH_SPACE, r_line, col1, scr_pkg::ST_CHAR);
                            n_col   = col1;
                        end
                        scr_pkg::CH_LPAREN: n_phase = scr_pkg::PH_PAREN;
                        scr_pkg::CH_BSLASH: n_phase = scr_pkg::PH_BSLASH;
                        default: begin
                            push.v0 = 1'b1;
                            push.r0 = mk(i_char_code, r_line, col1, scr_pkg::ST_CHAR);
                            n_col   = col1;
                        end
                    endcase
                end
                scr_pkg::PH_CRSKIP: n_phase = scr_pkg::PH_NORMAL;
                scr_pkg::PH_PAREN, scr_pkg::PH_BSLASH: begin
                    if (r_phase == scr_pkg::PH_PAREN && i_char_code == scr_pkg::CH_STAR) begin
                        n_phase = scr_pkg::PH_COMMENT;
                        n_depth = DepthOne;
                        n_mark  = MARK_STAR;
                    end else if (r_phase == scr_pkg::PH_BSLASH &&
                                 i_char_code == scr_pkg::CH_COLON) begin
                        n_phase    = scr_pkg::PH_HEX;
                        n_hex_cnt  = '0;
                        n_hex_acc  = '0;
                        n_hex_stop = 1'b0;
                    end else if (r_phase == scr_pkg::PH_BSLASH &&
                                 i_char_code == scr_pkg::CH_LBRACK) begin
                        n_phase    = scr_pkg::PH_NAMED;
                        n_name_len = '0;
                    end else if (r_phase == scr_pkg::PH_BSLASH &&
                                 (i_char_code == scr_pkg::CH_CR ||
                                  i_char_code == scr_pkg::CH_LF)) begin
                        // Line continuation
                        n_line  = line1;
                        n_col   = CntOne;
                        n_phase = (i_char_code == scr_pkg::CH_CR) ? scr_pkg::PH_CRSKIP
                                                                  : scr_pkg::PH_NORMAL;
                    end else begin
                        // Pending char goes out as it stands, then this char as normal
                        push.v0 = 1'b1;
                        push.r0 = mk((r_phase == scr_pkg::PH_PAREN) ? scr_pkg::CH_LPAREN
                                                                    : scr_pkg::CH_BSLASH,
                                     r_line, col1, scr_pkg::ST_CHAR);
                        n_phase = scr_pkg::PH_NORMAL;
                        n_col   = col1;
                        case (i_char_code)
                            scr_pkg::CH_CR, scr_pkg::CH_LF: begin
                                push.v1 = 1'b1;
                                push.r1 = mk(scr_pkg::CH_LF, line1, CntOne,
                                             scr_pkg::ST_CHAR);
                                n_line  = line1;
                                n_col   = CntOne;
                                if (i_char_code == scr_pkg::CH_CR) begin
                                    n_phase = scr_pkg::PH_CRSKIP;
                                end
                            end
                            scr_pkg::CH_TAB: begin
                                push.v1 = 1'b1;
                                push.r1 = mk(scr_pkg::CH_SPACE, r_line, col2,
                                             scr_pkg::ST_CHAR);
                                n_col   = col2;
                            end
                            scr_pkg::CH_LPAREN: n_phase = scr_pkg::PH_PAREN;
                            scr_pkg::CH_BSLASH: n_phase = scr_pkg::PH_BSLASH;
                            default: begin
                                push.v1 = 1'b1;
                                push.r1 = mk(i_char_code, r_line, col2, scr_pkg::ST_CHAR);
                                n_col   = col2;
                            end
                        endcase
                    end
                end
                scr_pkg::PH_HEX: begin
                    if (i_char_code == scr_pkg::CH_LF) begin
                        // Early end of the escape, then the newline itself
                        push.v0 = 1'b1;
                        push.r0 = mk(scr_pkg::CHAR_W'(r_hex_acc), r_line, col1,
                                     scr_pkg::ST_CHAR);
                        push.v1 = 1'b1;
                        push.r1 = mk(scr_pkg::CH_LF, line1, CntOne, scr_pkg::ST_CHAR);
                        n_line     = line1;
                        n_col      = CntOne;
                        n_phase    = scr_pkg::PH_NORMAL;
                        n_hex_cnt  = '0;
                        n_hex_acc  = '0;
                        n_hex_stop = 1'b0;
                    end else begin
                        if (!r_hex_stop && hv[4]) begin
                            acc = {r_hex_acc[scr_pkg::HEXACC_W-5:0], hv[3:0]};
                        end else begin
                            n_hex_stop = 1'b1;
                        end
                        n_hex_acc = acc;
                        n_hex_cnt = r_hex_cnt + 2'd1;
                        if (r_hex_cnt == scr_pkg::HEX_LAST_DIGIT) begin
                            push.v0    = 1'b1;
                            push.r0    = mk(scr_pkg::CHAR_W'(acc), r_line, col1,
                                            scr_pkg::ST_CHAR);
                            n_col      = col1;
                            n_phase    = scr_pkg::PH_NORMAL;
                            n_hex_cnt  = '0;
                            n_hex_acc  = '0;
                            n_hex_stop = 1'b0;
                        end
                    end
                end
                scr_pkg::PH_NAMED: begin
                    if (i_char_code == scr_pkg::CH_RBRACK) begin
                        push.v0    = 1'b1;
                        push.r0    = mk(scr_pkg::CH_NUL, r_line, col1, scr_pkg::ST_NAMED);
                        n_col      = col1;
                        n_phase    = scr_pkg::PH_NORMAL;
                        n_name_len = '0;
                    end else if (r_name_len != scr_pkg::NAME_LEN_MAX) begin
                        n_name_len = r_name_len + 1'b1;
                    end
                end
                scr_pkg::PH_COMMENT: begin
                    n_mark = MARK_NONE;
                    case (i_char_code)
                        scr_pkg::CH_STAR: begin
                            if (r_mark == MARK_PAREN) begin
                                if (r_depth >= DepthMax) begin
                                    push.v0 = 1'b1;
                                    push.r0 = mk(scr_pkg::CH_NUL, r_line, r_col,
                                                 scr_pkg::ST_DEPTH);
                                end else begin
                                    n_depth = r_depth + 1'b1;
                                end
                            end
                            n_col  = col1;
                            n_mark = MARK_STAR;
                        end
                        scr_pkg::CH_LPAREN: begin
                            n_col  = col1;
                            n_mark = MARK_PAREN;
                        end
                        scr_pkg::CH_RPAREN: begin
                            n_col = col1;
                            if (r_mark == MARK_STAR) begin
                                n_depth = r_depth - 1'b1;
                                if (r_depth == DepthOne) begin
                                    n_phase = scr_pkg::PH_NORMAL;
                                end
                            end
                        end
                        scr_pkg::CH_CR, scr_pkg::CH_LF: begin
                            n_line = line1;
                            n_col  = CntOne;
                            if (i_char_code == scr_pkg::CH_CR) begin
                                n_phase = scr_pkg::PH_CCRSKIP;
                            end
                        end
                        default: n_col = col1;  // tab delta already in d1
                    endcase
                end
                scr_pkg::PH_CCRSKIP: n_phase = scr_pkg::PH_COMMENT;
                default: n_phase = scr_pkg::PH_NORMAL;
            endcase
        end
    end

    assign o_push.v0 = push.v0 & i_accept;
    assign o_push.v1 = push.v1 & i_accept;
    assign o_push.r0 = push.r0;
    assign o_push.r1 = push.r1;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= scr_pkg::PH_NORMAL;
            r_depth       <= '0;
            r_mark        <= MARK_NONE;
            r_hex_cnt     <= '0;
            r_hex_acc     <= '0;
            r_hex_stop    <= 1'b0;
            r_name_len    <= '0;
            r_line        <= CntOne;
            r_col         <= CntOne;
            r_tab_advance <= scr_pkg::TAB_ADVANCE_RST;
        end else begin
            if (i_cfg_we) begin
                r_tab_advance <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_phase    <= n_phase;
                r_depth    <= n_depth;
                r_mark     <= n_mark;
                r_hex_cnt  <= n_hex_cnt;
                r_hex_acc  <= n_hex_acc;
                r_hex_stop <= n_hex_stop;
                r_name_len <= n_name_len;
                r_line     <= n_line;
                r_col      <= n_col;
            end
        end
    end

endmodule

// ===== rtl/core/scr_outq.sv =====
// Four-word result queue: takes up to two words per cycle, hands out one while the receiver is ready.
// Depends on scr_pkg for the result and push types.
module scr_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  scr_pkg::t_push   i_push,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output scr_pkg::t_result o_word
);
    localparam int CW = scr_pkg::OUTQ_AW + 1;

    scr_pkg::t_result                r_mem [scr_pkg::OUTQ_DEPTH];
    logic [scr_pkg::OUTQ_AW-1:0]     r_wr, n_wr, r_rd, n_rd, wr1;
    logic [CW-1:0]                   r_cnt, n_cnt;
    logic                            pop;

    // Room for two words keeps the input side free of the output handshake
    assign o_space = (r_cnt <= CW'(scr_pkg::OUTQ_DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rd];
    assign pop     = o_valid & i_ready;
    assign wr1     = r_wr + 1'b1;

    // Pointer and count update
    always_comb begin
        n_wr  = r_wr + {1'b0, i_push.v0} + {1'b0, i_push.v1};
        n_rd  = r_rd + {1'b0, pop};
        n_cnt = r_cnt + CW'(i_push.v0) + CW'(i_push.v1) - CW'(pop);
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[wr1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/source_char_reader_with_comments.sv =====
// Source character reader: one character word in, cleaned character words out,
// each with line and column. An input word is taken every cycle while the four-word
// output queue has room for two words; the step logic settles in the accept cycle
// and writes its one or two results straight into the queue registers. A word
// that produces two results (a pending "(" or backslash followed by an ordinary
// char, an escape cut short by a newline, any flush at end of input) needs one
// extra output word, absorbed by the queue. CR yields a newline and drops the
// following char, tabs become a space that advances the column by tab_advance,
// nested (* *) comments vanish, backslash-colon takes four hex chars,
// backslash-[name] reports status 3.
// Line and column counters saturate at 2^COUNTER_BITS-1; low 16 bits are shown.
// Depends on scr_pkg, scr_if, scr_core and scr_outq.
module source_char_reader_with_comments #(
    parameter int MAX_COMMENT_DEPTH = scr_pkg::MAX_COMMENT_DEPTH_DEF,
    parameter int COUNTER_BITS      = scr_pkg::COUNTER_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [scr_pkg::TAB_W-1:0] i_cfg_wdata,
    scr_in_if.sink                    i_char,
    scr_out_if.source                 o_result
);
    scr_pkg::t_push   push;
    scr_pkg::t_result word;
    logic             space;
    logic             accept;

    assign i_char.ready = space;
    assign accept       = i_char.valid & space;

    // Scanner step
    scr_core #(
        .MAX_COMMENT_DEPTH (MAX_COMMENT_DEPTH),
        .COUNTER_BITS      (COUNTER_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_accept       (accept),
        .i_char_code    (i_char.char_code),
        .i_end_of_input (i_char.end_of_input),
        .o_push         (push)
    );

    // Result queue
    scr_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_word  (word)
    );

    assign o_result.out_char      = word.out_char;
    assign o_result.line_number   = word.line_number;
    assign o_result.column_number = word.column_number;
    assign o_result.status        = word.status;

endmodule

// ===== bench/tb_source_char_reader_with_comments.sv =====
`timescale 1ns / 100ps
// Self-checking bench for source_char_reader_with_comments: directed and random words
// against a local model of the scanner. Depends on scr_pkg, scr_if and the RTL.
module tb_source_char_reader_with_comments;
    import scr_pkg::*;

    localparam int              DEPTH_MAX   = MAX_COMMENT_DEPTH_DEF;
    localparam int              CNT_BITS    = COUNTER_BITS_DEF;
    localparam longint unsigned CNT_MAX     = (64'd1 << CNT_BITS) - 1;
    localparam int              HEX_LEN     = 4;
    localparam int              SETTLE      = 4;
    localparam int              END_WAIT    = 10;
    localparam int              HOLD_CYCLES = 300;
    localparam int              MAX_PRINT   = 100;

    typedef enum logic [1:0] {MARK_NONE, MARK_STAR, MARK_PAREN} t_mark;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [TAB_W-1:0] cfg_wdata = '0;

    scr_in_if  char_if ();
    scr_out_if res_if ();

    source_char_reader_with_comments #(
        .MAX_COMMENT_DEPTH (DEPTH_MAX),
        .COUNTER_BITS      (CNT_BITS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_char      (char_if),
        .o_result    (res_if)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Scanner model state
    t_phase           rd_phase;
    int unsigned      nest_level;
    t_mark            last_mark;
    int unsigned      esc_taken;
    logic [15:0]      esc_code;
    bit               esc_halted;
    int unsigned      name_len;
    int unsigned      cur_line;
    int unsigned      cur_col;
    logic [TAB_W-1:0] tab_cols;

    t_result     clean_q[$];    // cleaned words still to come out
    int          err_count  = 0;
    int          items_sent = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    logic        rx_hold;
    event        hold_go;

    task automatic report_bad(input string what, input int unsigned got,
                              input int unsigned want);
        if (err_count < MAX_PRINT)
            $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        err_count++;
    endtask

    // ---------------- model ----------------

    function automatic int unsigned sat_sum(int unsigned a, int unsigned b);
        longint unsigned s;
        s = longint'(a) + longint'(b);
        return 32'((s > CNT_MAX) ? CNT_MAX : s);
    endfunction

    function automatic void push_clean(logic [CHAR_W-1:0] ch, t_status st);
        t_result r;
        r.out_char      = ch;
        r.line_number   = cur_line[15:0];
        r.column_number = cur_col[15:0];
        r.status        = st;
        clean_q.push_back(r);
    endfunction

    function automatic void bump_line();
        cur_line = sat_sum(cur_line, 1);
        cur_col  = 1;
    endfunction

    function automatic int hex_digit(logic [CHAR_W-1:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic void reset_reader();
        rd_phase   = PH_NORMAL;
        nest_level = 0;
        last_mark  = MARK_NONE;
        esc_taken  = 0;
        esc_code   = '0;
        esc_halted = 0;
        name_len   = 0;
        cur_line   = 1;
        cur_col    = 1;
        tab_cols   = TAB_ADVANCE_RST;
    endfunction

    function automatic void close_hex();
        cur_col = sat_sum(cur_col, HEX_ESC_COLS);
        push_clean({5'd0, esc_code}, ST_CHAR);
        rd_phase   = PH_NORMAL;
        esc_taken  = 0;
        esc_code   = '0;
        esc_halted = 0;
    endfunction

    // Character outside any sequence
    function automatic void plain_char(logic [CHAR_W-1:0] c);
        case (c)
            CH_CR: begin
                bump_line();
                push_clean(CH_LF, ST_CHAR);
                rd_phase = PH_CRSKIP;
            end
            CH_LF: begin
                bump_line();
                push_clean(CH_LF, ST_CHAR);
            end
            CH_TAB: begin
                cur_col = sat_sum(cur_col, 32'(tab_cols));
                push_clean(CH_SPACE, ST_CHAR);
            end
            CH_LPAREN: rd_phase = PH_PAREN;
            CH_BSLASH: rd_phase = PH_BSLASH;
            default: begin
                cur_col = sat_sum(cur_col, 1);
                push_clean(c, ST_CHAR);
            end
        endcase
    endfunction

    // Character inside a comment: counters, nesting and mark change; a too-deep opener queues a depth word
    function automatic void inside_comment(logic [CHAR_W-1:0] c);
        case (c)
            CH_STAR: begin
                if (last_mark == MARK_PAREN) begin
                    if (nest_level >= DEPTH_MAX) push_clean(CH_NUL, ST_DEPTH);
                    else nest_level++;
                end
                cur_col   = sat_sum(cur_col, 1);
                last_mark = MARK_STAR;
            end
            CH_LPAREN: begin
                cur_col   = sat_sum(cur_col, 1);
                last_mark = MARK_PAREN;
            end
            CH_RPAREN: begin
                cur_col = sat_sum(cur_col, 1);
                if (last_mark == MARK_STAR) begin
                    nest_level--;
                    if (nest_level == 0) rd_phase = PH_NORMAL;
                end
                last_mark = MARK_NONE;
            end
            CH_CR: begin
                bump_line();
                last_mark = MARK_NONE;
                rd_phase  = PH_CCRSKIP;
            end
            CH_LF: begin
                bump_line();
                last_mark = MARK_NONE;
            end
            CH_TAB: begin
                cur_col   = sat_sum(cur_col, 32'(tab_cols));
                last_mark = MARK_NONE;
            end
            default: begin
                cur_col   = sat_sum(cur_col, 1);
                last_mark = MARK_NONE;
            end
        endcase
    endfunction

    // One accepted input word: queue the cleaned words it causes
    function automatic void read_char(logic [CHAR_W-1:0] c, logic eoi);
        int v;
        if (eoi) begin
            // flush whatever is pending, then the end marker
            case (rd_phase)
                PH_PAREN: begin
                    cur_col = sat_sum(cur_col, 1);
                    push_clean(CH_LPAREN, ST_CHAR);
                end
                PH_BSLASH: begin
                    cur_col = sat_sum(cur_col, 1);
                    push_clean(CH_BSLASH, ST_CHAR);
                end
                PH_HEX: close_hex();
                PH_NAMED: begin
                    cur_col = sat_sum(cur_col, sat_sum(name_len, NAMED_ESC_COLS));
                    push_clean(CH_NUL, ST_NAMED);
                end
                PH_COMMENT, PH_CCRSKIP: push_clean(CH_NUL, ST_UNTERM);
                default: ;
            endcase
            rd_phase   = PH_NORMAL;
            nest_level = 0;
            last_mark  = MARK_NONE;
            esc_taken  = 0;
            esc_code   = '0;
            esc_halted = 0;
            name_len   = 0;
            push_clean(CH_NUL, ST_END);
        end else begin
            case (rd_phase)
                PH_NORMAL: plain_char(c);
                PH_CRSKIP: rd_phase = PH_NORMAL;
                PH_PAREN: begin
                    if (c == CH_STAR) begin
                        rd_phase   = PH_COMMENT;
                        nest_level = 1;
                        last_mark  = MARK_STAR;
                    end else begin
                        rd_phase = PH_NORMAL;
                        cur_col  = sat_sum(cur_col, 1);
                        push_clean(CH_LPAREN, ST_CHAR);
                        plain_char(c);
                    end
                end
                PH_BSLASH: begin
                    if (c == CH_COLON) begin
                        rd_phase   = PH_HEX;
                        esc_taken  = 0;
                        esc_code   = '0;
                        esc_halted = 0;
                    end else if (c == CH_LBRACK) begin
                        rd_phase = PH_NAMED;
                        name_len = 0;
                    end else if (c == CH_CR) begin
                        bump_line();
                        rd_phase = PH_CRSKIP;
                    end else if (c == CH_LF) begin
                        bump_line();
                        rd_phase = PH_NORMAL;
                    end else begin
                        rd_phase = PH_NORMAL;
                        cur_col  = sat_sum(cur_col, 1);
                        push_clean(CH_BSLASH, ST_CHAR);
                        plain_char(c);
                    end
                end
                PH_HEX: begin
                    if (c == CH_LF) begin
                        // newline cuts the escape short and is then taken as usual
                        close_hex();
                        plain_char(c);
                    end else begin
                        v = hex_digit(c);
                        if (!esc_halted && v >= 0) esc_code = {esc_code[11:0], v[3:0]};
                        else esc_halted = 1;
                        esc_taken++;
                        if (esc_taken >= HEX_LEN) close_hex();
                    end
                end
                PH_NAMED: begin
                    if (c == CH_RBRACK) begin
                        cur_col = sat_sum(cur_col, sat_sum(name_len, NAMED_ESC_COLS));
                        push_clean(CH_NUL, ST_NAMED);
                        rd_phase = PH_NORMAL;
                        name_len = 0;
                    end else if (name_len < NAME_LEN_MAX) begin
                        name_len++;
                    end
                end
                PH_COMMENT: inside_comment(c);
                default: rd_phase = PH_COMMENT;
            endcase
        end
    endfunction

    // ---------------- result side ----------------

    // Long receiver hold-off, counted here
    initial begin
        rx_hold = 1'b0;
        forever begin
            @(hold_go);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    // Check each accepted result word, then pick the next ready
    always @(posedge clk) begin : result_check
        t_result want;
        if (res_if.valid && res_if.ready) begin
            if (clean_q.size() == 0) begin
                report_bad("unexpected word", 32'(res_if.out_char), 0);
            end else begin
                want = clean_q.pop_front();
                if (res_if.out_char !== want.out_char)
                    report_bad("out_char", 32'(res_if.out_char), 32'(want.out_char));
                if (res_if.line_number !== want.line_number)
                    report_bad("line_number", 32'(res_if.line_number),
                               32'(want.line_number));
                if (res_if.column_number !== want.column_number)
                    report_bad("column_number", 32'(res_if.column_number),
                               32'(want.column_number));
                if (res_if.status !== want.status)
                    report_bad("status", 32'(res_if.status), 32'(want.status));
            end
        end
        res_if.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // ---------------- input side ----------------

    // Offer one word; valid stays high after acceptance unless a gap follows
    task automatic send_char(input logic [CHAR_W-1:0] code, input logic eoi);
        while ($urandom_range(99) < tx_idle_pct) begin
            char_if.valid <= 1'b0;
            @(posedge clk);
        end
        char_if.valid        <= 1'b1;
        char_if.char_code    <= code;
        char_if.end_of_input <= eoi;
        do @(posedge clk); while (!char_if.ready);
        read_char(code, eoi);
        items_sent++;
    endtask

    task automatic send_str(input string s);
        foreach (s[i]) send_char({13'd0, s[i]}, 1'b0);
    endtask

    task automatic send_end();
        send_char(CHAR_W'($urandom_range(21'h10FFFF)), 1'b1);
    endtask

    // Stop offering and let every expected word come out
    task automatic drain();
        char_if.valid <= 1'b0;
        while (clean_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_tab(input logic [TAB_W-1:0] cols);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= cols;
        @(posedge clk);
        cfg_we   <= 1'b0;
        tab_cols = cols;
    endtask

    // ---------------- random content ----------------

    function automatic logic [CHAR_W-1:0] any_char();
        if ($urandom_range(1)) return CHAR_W'($urandom_range(32, 126));
        return CHAR_W'($urandom_range(21'h10FFFF));
    endfunction

    function automatic logic [CHAR_W-1:0] comment_pick();
        string pool = "(*)ab \t\n\r";
        if ($urandom_range(9) == 0) return any_char();
        return {13'd0, pool[$urandom_range(pool.len() - 1)]};
    endfunction

    function automatic logic [CHAR_W-1:0] hex_pick();
        string pool = "0123456789abcdefABCDEF";
        int unsigned p;
        p = $urandom_range(99);
        if (p < 80) return {13'd0, pool[$urandom_range(pool.len() - 1)]};
        if (p < 92) return CHAR_W'($urandom_range(32, 126));
        return CH_LF;
    endfunction

    // Comment with random body; when closed, keep closing until back to text
    task automatic send_comment(input int unsigned len, input bit closed);
        send_str("(*");
        repeat (len) send_char(comment_pick(), 1'b0);
        if (closed)
            while (rd_phase inside {PH_COMMENT, PH_CCRSKIP}) send_str("*)");
    endtask

    task automatic random_token();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 25) begin
            send_char(CHAR_W'($urandom_range(32, 126)), 1'b0);
        end else if (pick < 32) begin
            send_char(CHAR_W'($urandom_range(21'h10FFFF)), 1'b0);
        end else if (pick < 40) begin
            case ($urandom_range(2))
                0: send_char(CH_LF, 1'b0);
                1: begin
                    send_char(CH_CR, 1'b0);
                    send_char(any_char(), 1'b0);
                end
                default: send_char(CH_TAB, 1'b0);
            endcase
        end else if (pick < 55) begin
            send_comment($urandom_range(12), 1'b1);
        end else if (pick < 67) begin
            send_str("\\:");
            repeat (HEX_LEN) send_char(hex_pick(), 1'b0);
        end else if (pick < 77) begin
            send_str("\\[");
            repeat ($urandom_range(8))
                send_char(CHAR_W'($urandom_range("a", "z")), 1'b0);
            send_char(CH_RBRACK, 1'b0);
        end else if (pick < 83) begin
            if ($urandom_range(1)) begin
                send_str("\\\n");
            end else begin
                send_str("\\\r");
                send_char(any_char(), 1'b0);
            end
        end else if (pick < 93) begin
            // lone paren or backslash followed by anything
            send_char($urandom_range(1) ? CH_LPAREN : CH_BSLASH, 1'b0);
            send_char(any_char(), 1'b0);
        end else if (pick < 97) begin
            if ($urandom_range(1)) begin
                send_comment($urandom_range(6), 1'b0);
            end else begin
                send_str("\\:");
                repeat ($urandom_range(HEX_LEN - 1)) send_char(hex_pick(), 1'b0);
            end
            send_end();
        end else begin
            send_end();
        end
    endtask

    // ---------------- tests ----------------

    // Field extremes, line breaks and tabs at several tab settings
    task automatic test_plain_chars();
        send_str("A");
        send_char(21'h10FFFF, 1'b0);
        send_char(CH_NUL, 1'b0);
        send_char(21'h0F0F0F, 1'b0);
        send_str("\n\rx\r\n\t");
        write_tab(5'd0);
        send_char(CH_TAB, 1'b0);
        write_tab(5'd16);
        send_char(CH_TAB, 1'b0);
        write_tab(TAB_ADVANCE_RST);
    endtask

    // Pending paren/backslash before ordinary chars, continuations, "(*)"
    task automatic test_pending();
        send_str("(b(\n\\q\\\\x\\\ny\\\rzw((*)");
    endtask

    // Full escape, mixed case, early stop on non-hex, no digit, cut by newline
    task automatic test_hex_escape();
        send_str("\\:FFFF\\:00e9\\:fG12\\:x123\\:4\n");
    endtask

    task automatic test_named_escape();
        send_str("\\[]\\[abc]\\[\\[]k");
    endtask

    // Plain, nested, "(**)", CR and tab inside a comment
    task automatic test_comments();
        send_str("(*x*)b(*(*y*)*)d(**)(*\r*\t*)f");
    endtask

    // Nest to the limit, one more opener, then close all
    task automatic test_depth_overflow();
        send_end();
        send_str("(*");
        repeat (DEPTH_MAX - 1) send_str("(*");
        send_str("(*");
        repeat (DEPTH_MAX) send_str("*)");
        send_str("e");
    endtask

    // End of input from every pending phase
    task automatic test_end_flush();
        send_str("(");
        send_end();
        send_str("\\");
        send_end();
        send_str("\\:1");
        send_end();
        send_str("\\[ab");
        send_end();
        send_str("(*zz");
        send_end();
        send_str("(*\r");
        send_end();
        send_str("\r");
        send_end();
        send_str("q");
        send_end();
        send_end();
    endtask

    task automatic test_random(input logic [TAB_W-1:0] cols, input int unsigned tx_pct,
                               input int unsigned rx_pct, input int count);
        int target;
        write_tab(cols);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target = items_sent + count;
        while (items_sent < target) random_token();
    endtask

    // Receiver stops for a long stretch while words keep coming
    task automatic test_backpressure();
        drain();
        -> hold_go;
        repeat (30) begin
            send_char(CHAR_W'($urandom_range(32, 126)), 1'b0);
            send_str("(b\t");
        end
    endtask

    // Widest tab setting mixed with escapes, a comment and a name cut by the end
    task automatic test_wide_tab();
        write_tab(5'd31);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (8) send_char(CH_TAB, 1'b0);
        send_str("z\\:1234\\[q](*\t*)\n\\[r");
        send_end();
    endtask

    // ---------------- sequence ----------------

    initial begin
        char_if.valid        = 1'b0;
        char_if.char_code    = '0;
        char_if.end_of_input = 1'b0;
        reset_reader();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 20;
        rx_idle_pct = 80;
        test_plain_chars();
        test_pending();
        test_hex_escape();
        test_named_escape();
        test_comments();
        test_depth_overflow();
        test_end_flush();
        test_random(5'd1, 20, 80, 120);
        test_random(5'd16, 80, 20, 120);
        test_random(5'd31, 0, 0, 120);
        test_backpressure();
        test_wide_tab();

        drain();
        repeat (END_WAIT) @(posedge clk);
        if (err_count == 0) begin
            $display("tb_source_char_reader_with_comments OK");
        end else begin
            $display("tb_source_char_reader_with_comments NOT OK");
        end
        $finish;
    end

    // Hard stop well past the slowest correct run
    initial begin
        #5_000_000;
        $display("tb_source_char_reader_with_comments NOT OK");
        $finish;
    end

endmodule

// ===== source_char_reader_with_comments.f =====
rtl/core/scr_pkg.sv
rtl/core/scr_if.sv
rtl/core/scr_core.sv
rtl/core/scr_outq.sv
rtl/core/source_char_reader_with_comments.sv
bench/tb_source_char_reader_with_comments.sv
